// ===== src/npc_pkg.sv =====
// Package for the nearest palette color search block.
// Holds the color word type, mode codes and the sequencer state type.
// No dependencies.
package npc_pkg;

	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned INDEX_W = 8;
	// 3 * 255^2 = 195075 fits in 18 bits
	localparam int unsigned SQ_W    = 2 * CHAN_W;
	localparam int unsigned DIST_W  = SQ_W + 2;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_QUERY = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_FIN    = 3'b100
	} state_t;

endpackage

// ===== src/npc_cmd_if.sv =====
// Command channel: palette writes and color queries.
// Depends on npc_pkg.
interface npc_cmd_if;
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic [npc_pkg::INDEX_W-1:0] entry_index;
	logic [npc_pkg::CHAN_W-1:0]  red;
	logic [npc_pkg::CHAN_W-1:0]  green;
	logic [npc_pkg::CHAN_W-1:0]  blue;

	modport source (output valid, mode, entry_index, red, green, blue, input ready);
	modport sink (input valid, mode, entry_index, red, green, blue, output ready);
endinterface

// ===== src/npc_res_if.sv =====
// Result channel: index of the nearest palette entry.
// Depends on npc_pkg.
interface npc_res_if;
	logic                         valid;
	logic                         ready;
	logic [npc_pkg::INDEX_W-1:0] best_index;

	modport source (output valid, best_index, input ready);
	modport sink (input valid, best_index, output ready);
endinterface

// ===== src/npc_palette_mem.sv =====
// Palette storage: one write port, one read port, registered read data.
// Depends on npc_pkg.
module npc_palette_mem #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  npc_pkg::rgb_t       wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output npc_pkg::rgb_t       rdata_s1
);

	npc_pkg::rgb_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data registered while re is high
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

endmodule

// ===== src/npc_dist.sv =====
// Squared RGB distance stage between a query color and one palette entry.
// Depends on npc_pkg.
module npc_dist #(
	parameter int unsigned AW = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          flush,
	input  logic                          valid_s1,
	input  logic [AW-1:0]                 idx_s1,
	input  npc_pkg::rgb_t                 query,
	input  npc_pkg::rgb_t                 entry_s1,
	output logic                          valid_s2,
	output logic [AW-1:0]                 idx_s2,
	output logic [npc_pkg::DIST_W-1:0]    dist_s2
);

	logic [npc_pkg::CHAN_W-1:0] dr, dg, db;
	logic [npc_pkg::SQ_W-1:0]   sr, sg, sb;
	logic [npc_pkg::DIST_W-1:0] sum;

	// absolute channel differences and their squares
	always_comb begin
		dr  = (query.red   > entry_s1.red)   ? query.red   - entry_s1.red
		                                     : entry_s1.red   - query.red;
		dg  = (query.green > entry_s1.green) ? query.green - entry_s1.green
		                                     : entry_s1.green - query.green;
		db  = (query.blue  > entry_s1.blue)  ? query.blue  - entry_s1.blue
		                                     : entry_s1.blue  - query.blue;
		sr  = dr * dr;
		sg  = dg * dg;
		sb  = db * db;
		sum = npc_pkg::DIST_W'(sr) + npc_pkg::DIST_W'(sg) + npc_pkg::DIST_W'(sb);
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 && !flush;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		idx_s2  <= idx_s1;
		dist_s2 <= sum;
	end

endmodule

// ===== src/nearest_palette_color.sv =====
// Nearest palette color search, top level: sequencer, best-match tracking, result register.
// Depends on npc_pkg, npc_cmd_if, npc_res_if, npc_palette_mem, npc_dist.
//
//  channel | dir | payload                                  | handshake
//  cmd     | in  | mode, entry_index, red, green, blue      | valid/ready
//  res     | out | best_index                               | valid/ready
//
// A write word is stored at once; it gives no result.
// A query walks the palette one entry per cycle through the memory read port.
// Its result word becomes valid after the last entry, or after the first exact match,
// and cmd is ready again in the cycle in which it becomes valid.
// cmd is ready only while no query runs.
// A stalled result holds the block in its final state; reset clears control only.
module nearest_palette_color #(
	parameter int unsigned PALETTE_ENTRIES = 256
) (
	input logic      clk,
	input logic      arst_n,
	npc_cmd_if.sink  cmd,
	npc_res_if.source res
);

	localparam int unsigned AW   = $clog2(PALETTE_ENTRIES);
	localparam int unsigned CW   = (AW > npc_pkg::INDEX_W) ? AW : npc_pkg::INDEX_W;
	localparam logic [AW-1:0] LAST = AW'(PALETTE_ENTRIES - 1);

	npc_pkg::state_t            state_q;
	logic                       issuing_q;
	logic [AW-1:0]              addr_q;
	logic                       valid_s1;
	logic [AW-1:0]              idx_s1;
	npc_pkg::rgb_t              rdata_s1;
	logic                       valid_s2;
	logic [AW-1:0]              idx_s2;
	logic [npc_pkg::DIST_W-1:0] dist_s2;
	npc_pkg::rgb_t              query_q;
	logic                       have_q;
	logic [AW-1:0]              best_idx_q;
	logic [npc_pkg::DIST_W-1:0] best_dist_q;
	logic                       res_valid_q;
	logic [npc_pkg::INDEX_W-1:0] res_idx_q;

	logic          cmd_acc;
	logic          wr_en;
	logic          query_acc;
	logic [CW-1:0] widx_wide;
	npc_pkg::rgb_t wdata;
	logic          searching;
	logic          better;
	logic          finish;
	logic          flush;
	logic          res_load;
	logic [CW-1:0] best_wide;

	// input decode
	always_comb begin
		cmd_acc   = cmd.valid && cmd.ready;
		widx_wide = CW'(cmd.entry_index);
		wr_en     = cmd_acc && (cmd.mode == npc_pkg::MODE_WRITE)
		            && (32'(cmd.entry_index) < 32'(PALETTE_ENTRIES));
		query_acc = cmd_acc && (cmd.mode == npc_pkg::MODE_QUERY);
		wdata     = '{red: cmd.red, green: cmd.green, blue: cmd.blue};
	end

	assign cmd.ready = (state_q == npc_pkg::ST_IDLE);

	// compare stage: strictly smaller replaces, an exact match or the last entry ends the walk
	always_comb begin
		searching = (state_q == npc_pkg::ST_SEARCH);
		better    = !have_q || (dist_s2 < best_dist_q);
		finish    = searching && valid_s2 && ((better && dist_s2 == '0) || idx_s2 == LAST);
		flush     = finish || !searching;
		res_load  = (state_q == npc_pkg::ST_FIN) && (!res_valid_q || res.ready);
		best_wide = CW'(best_idx_q);
	end

	npc_palette_mem #(
		.DEPTH (PALETTE_ENTRIES),
		.AW    (AW)
	) u_mem (
		.clk      (clk),
		.we       (wr_en),
		.waddr    (widx_wide[AW-1:0]),
		.wdata    (wdata),
		.re       (issuing_q),
		.raddr    (addr_q),
		.rdata_s1 (rdata_s1)
	);

	npc_dist #(
		.AW (AW)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.flush    (flush),
		.valid_s1 (valid_s1),
		.idx_s1   (idx_s1),
		.query    (query_q),
		.entry_s1 (rdata_s1),
		.valid_s2 (valid_s2),
		.idx_s2   (idx_s2),
		.dist_s2  (dist_s2)
	);

	// sequencer and read address counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= npc_pkg::ST_IDLE;
			issuing_q <= 1'b0;
			addr_q    <= '0;
			valid_s1  <= 1'b0;
			have_q    <= 1'b0;
		end else begin
			valid_s1 <= issuing_q && searching && !finish;
			case (state_q)
				npc_pkg::ST_IDLE: begin
					if (query_acc) begin
						state_q   <= npc_pkg::ST_SEARCH;
						issuing_q <= 1'b1;
						addr_q    <= '0;
						have_q    <= 1'b0;
					end
				end
				npc_pkg::ST_SEARCH: begin
					if (finish) begin
						issuing_q <= 1'b0;
						state_q   <= npc_pkg::ST_FIN;
					end else if (issuing_q) begin
						if (addr_q == LAST) begin
							issuing_q <= 1'b0;
						end else begin
							addr_q <= addr_q + 1'b1;
						end
					end
					if (valid_s2 && better) begin
						have_q <= 1'b1;
					end
				end
				npc_pkg::ST_FIN: begin
					if (res_load) begin
						state_q <= npc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q   <= npc_pkg::ST_IDLE;
					issuing_q <= 1'b0;
				end
			endcase
		end
	end

	// query color, best match and read tag
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (query_acc) begin
			query_q    <= wdata;
			best_idx_q <= '0;
		end else if (searching && valid_s2 && better) begin
			best_idx_q  <= idx_s2;
			best_dist_q <= dist_s2;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_idx_q <= best_wide[npc_pkg::INDEX_W-1:0];
		end
	end

	assign res.valid      = res_valid_q;
	assign res.best_index = res_idx_q;

	// an exact match always ends the walk, so a kept best is never zero away
	a_best_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(searching && have_q) |-> (best_dist_q != '0))
		else $error("kept best distance is zero during search");

	// compare stage only carries words during a search
	a_s2_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> searching)
		else $error("distance word outside search");

	// leaving the final state always presents a result
	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (res_valid_q && state_q == npc_pkg::ST_IDLE))
		else $error("result not presented after search");

	// reads are issued only while searching
	a_issue_search: assert property (@(posedge clk) disable iff (!arst_n)
		issuing_q |-> searching)
		else $error("palette read outside search");

endmodule

// ===== sim/tb_nearest_palette_color.sv =====
// Self-checking testbench for nearest_palette_color: palette fill, directed table, random mix.
// Expects each query result from a typed row or its palette copy; checks every result in order.
// Depends on npc_pkg, npc_cmd_if, npc_res_if and the nearest_palette_color RTL.
module tb_nearest_palette_color;
	timeunit 1ns;
	timeprecision 1ps;

	import npc_pkg::*;

	localparam int unsigned ENTRIES     = 256;
	localparam int unsigned CLK_HALF    = 4;
	localparam int unsigned RESET_CYC   = 7;
	localparam int unsigned RAND_ITEMS  = 135;
	localparam int unsigned SHADE_N     = 6;
	// drain wait after the last result, with margin
	localparam int unsigned DRAIN_CYC   = 2 * (ENTRIES + 3) + 64;
	localparam int unsigned CYCLE_LIMIT = 5_000_000;
	localparam int unsigned DIR_N       = 21;

	typedef struct packed {
		mode_t             mode;
		logic [INDEX_W-1:0] idx;
		rgb_t              color;
		logic              has_exp;
		logic [INDEX_W-1:0] exp;
	} dir_row_t;

	logic clk;
	logic arst_n;

	npc_cmd_if cmd_ch ();
	npc_res_if res_ch ();

	nearest_palette_color #(
		.PALETTE_ENTRIES(ENTRIES)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.res   (res_ch)
	);

	rgb_t               palette_copy [ENTRIES];
	logic [INDEX_W-1:0] best_index_q [$];
	rgb_t               shade_set [SHADE_N];
	dir_row_t           dir_tab [DIR_N];
	int                 mismatch_count;
	bit                 calm;
	longint             cycle_count;

	// clock
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// run length guard
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// idle length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(50, 200);
	endfunction

	// channel value that favors the extremes
	function automatic logic [CHAN_W-1:0] rand_chan();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return CHAN_W'($urandom_range(0, 255));
	endfunction

	// small random offset, saturated to the channel range
	function automatic logic [CHAN_W-1:0] nudge(logic [CHAN_W-1:0] v);
		int x;
		x = int'(v) + int'($urandom_range(0, 6)) - 3;
		if (x < 0)
			x = 0;
		if (x > 255)
			x = 255;
		return CHAN_W'(x);
	endfunction

	// nearest entry by squared distance; ties keep the lower index, exact match stops
	function automatic logic [INDEX_W-1:0] nearest_shade(rgb_t c);
		int best;
		int best_d;
		int d;
		int dr;
		int dg;
		int db;
		best = 0;
		best_d = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			dr = int'(c.red) - int'(palette_copy[i].red);
			dg = int'(c.green) - int'(palette_copy[i].green);
			db = int'(c.blue) - int'(palette_copy[i].blue);
			d = dr * dr + dg * dg + db * db;
			if (i == 0 || d < best_d) begin
				if (d == 0)
					return INDEX_W'(i);
				best_d = d;
				best = i;
			end
		end
		return INDEX_W'(best);
	endfunction

	// drive one command word and wait for its acceptance; queue the result of a query
	task automatic send_word(mode_t m, logic [INDEX_W-1:0] idx, rgb_t c,
			logic has_exp, logic [INDEX_W-1:0] exp);
		int n;
		n = calm ? 0 : pick_gap();
		if (n > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.mode        <= m;
		cmd_ch.entry_index <= idx;
		cmd_ch.red         <= c.red;
		cmd_ch.green       <= c.green;
		cmd_ch.blue        <= c.blue;
		// ready is stable between edges; sample it mid-cycle
		do @(negedge clk); while (cmd_ch.ready !== 1'b1);
		@(posedge clk);
		if (m == MODE_WRITE)
			palette_copy[idx] = c;
		else
			best_index_q.push_back(has_exp ? exp : nearest_shade(c));
	endtask

	// random mix of writes and queries
	task automatic run_random(int count, bit few_colors);
		int   r;
		rgb_t c;
		for (int k = 0; k < count; k++) begin
			if (few_colors)
				calm = (k < count / 4);
			r = $urandom_range(0, 99);
			if (r < 35) begin
				if (few_colors)
					c = shade_set[$urandom_range(0, SHADE_N - 1)];
				else
					c = '{rand_chan(), rand_chan(), rand_chan()};
				send_word(MODE_WRITE, INDEX_W'($urandom_range(0, 255)), c, 1'b0, '0);
			end else begin
				if (r < 55) begin
					c = palette_copy[$urandom_range(0, ENTRIES - 1)];
				end else if (r < 75) begin
					c = palette_copy[$urandom_range(0, ENTRIES - 1)];
					c = '{nudge(c.red), nudge(c.green), nudge(c.blue)};
				end else begin
					c = '{rand_chan(), rand_chan(), rand_chan()};
				end
				send_word(MODE_QUERY, INDEX_W'($urandom_range(0, 255)), c, 1'b0, '0);
			end
		end
		calm = 1'b0;
	endtask

	// result sink: random back-pressure
	initial begin
		int n;
		res_ch.ready = 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			n = calm ? 0 : pick_gap();
			if (n > 0) begin
				res_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	// result checker: samples mid-cycle and checks each word with valid and ready high
	always @(negedge clk) begin : chk
		logic [INDEX_W-1:0] want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (best_index_q.size() == 0) begin
				$display("%0t: result word best_index %0d with nothing expected",
					$time, res_ch.best_index);
				mismatch_count++;
			end else begin
				want = best_index_q.pop_front();
				if (res_ch.best_index !== want) begin
					$display("%0t: best_index expected %0d, actual %0d",
						$time, want, res_ch.best_index);
					mismatch_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		mismatch_count     = 0;
		calm               = 1'b0;
		arst_n             = 1'b0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.mode        = MODE_WRITE;
		cmd_ch.entry_index = '0;
		cmd_ch.red         = '0;
		cmd_ch.green       = '0;
		cmd_ch.blue        = '0;
		for (int i = 0; i < ENTRIES; i++)
			palette_copy[i] = '0;

		// directed rows; expectation typed where it is obvious, else predicted
		dir_tab = '{
			'{MODE_QUERY, 8'd0,   '{8'd0,   8'd0,   8'd0},   1'b1, 8'd0},   // black
			'{MODE_QUERY, 8'd0,   '{8'd255, 8'd255, 8'd255}, 1'b1, 8'd255}, // white
			'{MODE_QUERY, 8'd0,   '{8'd128, 8'd128, 8'd128}, 1'b1, 8'd128},
			'{MODE_QUERY, 8'd0,   '{8'd255, 8'd0,   8'd0},   1'b0, 8'd0},
			'{MODE_QUERY, 8'd0,   '{8'd0,   8'd255, 8'd255}, 1'b0, 8'd0},
			'{MODE_QUERY, 8'd0,   '{8'd1,   8'd2,   8'd1},   1'b0, 8'd0},
			// duplicate color: lower index wins
			'{MODE_WRITE, 8'd200, '{8'd17,  8'd17,  8'd17},  1'b0, 8'd0},
			'{MODE_QUERY, 8'd0,   '{8'd17,  8'd17,  8'd17},  1'b1, 8'd17},
			// exact match on the first entry
			'{MODE_WRITE, 8'd0,   '{8'd255, 8'd0,   8'd0},   1'b0, 8'd0},
			'{MODE_QUERY, 8'd0,   '{8'd255, 8'd0,   8'd0},   1'b1, 8'd0},
			'{MODE_QUERY, 8'd0,   '{8'd250, 8'd5,   8'd5},   1'b0, 8'd0},
			// exact match on the last entry, full walk
			'{MODE_WRITE, 8'd255, '{8'd0,   8'd0,   8'd255}, 1'b0, 8'd0},
			'{MODE_QUERY, 8'd0,   '{8'd0,   8'd0,   8'd255}, 1'b1, 8'd255},
			'{MODE_QUERY, 8'd0,   '{8'd255, 8'd255, 8'd255}, 1'b0, 8'd0},
			// equal nonzero distance to entries 70 and 71
			'{MODE_WRITE, 8'd70,  '{8'd70,  8'd70,  8'd72},  1'b0, 8'd0},
			'{MODE_WRITE, 8'd71,  '{8'd70,  8'd70,  8'd70},  1'b0, 8'd0},
			'{MODE_QUERY, 8'd0,   '{8'd70,  8'd70,  8'd71},  1'b1, 8'd70},
			'{MODE_QUERY, 8'd0,   '{8'd0,   8'd0,   8'd0},   1'b0, 8'd0},
			'{MODE_WRITE, 8'd128, '{8'd0,   8'd255, 8'd0},   1'b0, 8'd0},
			'{MODE_QUERY, 8'd0,   '{8'd0,   8'd255, 8'd0},   1'b1, 8'd128},
			// entry_index is ignored on a query
			'{MODE_QUERY, 8'd255, '{8'd0,   8'd0,   8'd0},   1'b0, 8'd0}
		};

		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// gray ramp: every entry written before any query
		for (int i = 0; i < ENTRIES; i++)
			send_word(MODE_WRITE, INDEX_W'(i), '{CHAN_W'(i), CHAN_W'(i), CHAN_W'(i)},
				1'b0, '0);

		for (int i = 0; i < DIR_N; i++)
			send_word(dir_tab[i].mode, dir_tab[i].idx, dir_tab[i].color,
				dir_tab[i].has_exp, dir_tab[i].exp);

		run_random(RAND_ITEMS, 1'b0);

		// refill from a few colors so that ties are common
		for (int s = 0; s < SHADE_N; s++)
			shade_set[s] = '{rand_chan(), rand_chan(), rand_chan()};
		for (int i = 0; i < ENTRIES; i++)
			send_word(MODE_WRITE, INDEX_W'(i), shade_set[$urandom_range(0, SHADE_N - 1)],
				1'b0, '0);

		run_random(RAND_ITEMS, 1'b1);

		cmd_ch.valid <= 1'b0;
		while (best_index_q.size() > 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
